[rtl/lzwc_pkg.sv]
// Package for the 12-bit LZW compressor.
// Holds the shared types and fixed constants. It depends on nothing.
package lzwc_pkg;

   localparam int BYTE_BITS     = 8;
   localparam int FIRST_LEARNED = 256;
   localparam int EPOCH_BITS    = 4;

   // One byte waiting between the front and the back.
   typedef struct packed {
      logic [BYTE_BITS-1:0] data_byte;
      logic                 final_byte;
      logic                 first_byte;
   } item_type;

   // Status that the back reports to the front.
   typedef struct packed {
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_EMIT_MISS,
      ST_EMIT_LAST
   } back_state_type;

endpackage

[rtl/lzwc_if.sv]
// Valid/ready channel interfaces for the LZW compressor.
// Depends on lzwc_pkg for the byte width.
interface lzw_req_if import lzwc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] data_byte;
   logic                 final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface lzw_rsp_if #(parameter int CODE_BITS = 12) ();
   logic                 valid;
   logic                 ready;
   logic [CODE_BITS-1:0] out_code;
   logic                 end_of_message;

   modport source (output valid, output out_code, output end_of_message, input ready);
   modport sink (input valid, input out_code, input end_of_message, output ready);
endinterface

[rtl/lzwc_front.sv]
// Front of the LZW compressor: accepts bytes, marks the first byte of each
// message and holds them in a two-word queue. Depends on lzwc_pkg, lzw_req_if.
module lzwc_front import lzwc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   lzw_req_if.sink         req_chan,
   input  back_status_type status,
   output item_type        item,
   output logic            item_valid,
   input  logic            item_pop
);

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       first_ff, first_in;
   logic       push;

   assign req_chan.ready = (count_ff != 2'd2) && !status.clearing;
   assign push           = req_chan.valid && req_chan.ready;
   assign item           = q_ff[rd_ptr_ff];
   assign item_valid     = (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ item_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop};
      first_in  = first_ff;
      // the byte after a final one opens a new message
      if (push) begin
         first_in = req_chan.final_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
         first_ff  <= 1'b1;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         first_ff  <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{data_byte:  req_chan.data_byte,
                              final_byte: req_chan.final_byte,
                              first_byte: first_ff};
      end
   end

endmodule

[rtl/lzwc_back.sv]
// Back of the LZW compressor: hashed dictionary with linear probing, the
// match state machine and the result register. Depends on lzwc_pkg, lzw_rsp_if.
module lzwc_back import lzwc_pkg::*; #(
   parameter int DICT_ENTRIES = 4096,
   parameter int CODE_BITS    = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  item_type        item,
   input  logic            item_valid,
   output logic            item_pop,
   output back_status_type status,
   lzw_rsp_if.source       rsp_chan
);

   localparam int CODE_LIMIT = (DICT_ENTRIES < (2 ** CODE_BITS)) ? DICT_ENTRIES
                                                                  : (2 ** CODE_BITS);
   localparam int NFW   = $clog2(CODE_LIMIT + 1);
   localparam int SB    = $clog2(DICT_ENTRIES) + 1;
   localparam int SLOTS = 2 ** SB;
   localparam int EW    = EPOCH_BITS + CODE_BITS + BYTE_BITS + CODE_BITS;

   logic [EW-1:0] mem [SLOTS];
   logic [EW-1:0] rd_ff;

   back_state_type       state_ff, state_in;
   logic [SB-1:0]        slot_ff, slot_in;
   logic [SB-1:0]        clr_ff, clr_in;
   logic [BYTE_BITS-1:0] byte_ff, byte_in;
   logic                 final_ff, final_in;
   logic [CODE_BITS-1:0] prefix_ff, prefix_in;
   logic [NFW-1:0]       next_free_ff, next_free_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic                 out_valid_ff, out_valid_in;
   logic [CODE_BITS-1:0] out_code_ff, out_code_in;
   logic                 out_end_ff, out_end_in;

   logic                 wr_en;
   logic [SB-1:0]        wr_addr;
   logic [EW-1:0]        wr_data;
   logic                 out_free;

   logic [EPOCH_BITS-1:0] rd_epoch;
   logic [CODE_BITS-1:0]  rd_prefix;
   logic [BYTE_BITS-1:0]  rd_byte;
   logic [CODE_BITS-1:0]  rd_code;

   assign rd_epoch  = rd_ff[EW-1 -: EPOCH_BITS];
   assign rd_prefix = rd_ff[2*CODE_BITS+BYTE_BITS-1 -: CODE_BITS];
   assign rd_byte   = rd_ff[CODE_BITS+BYTE_BITS-1 -: BYTE_BITS];
   assign rd_code   = rd_ff[CODE_BITS-1:0];

   assign out_free        = !out_valid_ff || rsp_chan.ready;
   assign status.clearing = (state_ff == ST_CLEAR);

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.out_code       = out_code_ff;
   assign rsp_chan.end_of_message = out_end_ff;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      clr_in       = clr_ff;
      byte_in      = byte_ff;
      final_in     = final_ff;
      prefix_in    = prefix_ff;
      next_free_in = next_free_ff;
      epoch_in     = epoch_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_code_in  = out_code_ff;
      out_end_in   = out_end_ff;
      item_pop     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = slot_ff;
      wr_data      = {epoch_ff, prefix_ff, byte_ff, CODE_BITS'(next_free_ff)};

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SB'(SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               byte_in  = item.data_byte;
               final_in = item.final_byte;
               if (item.first_byte) begin
                  prefix_in = CODE_BITS'(item.data_byte);
                  state_in  = item.final_byte ? ST_EMIT_LAST : ST_IDLE;
               end else begin
                  slot_in  = SB'(prefix_ff) ^ (SB'(item.data_byte) << (SB - BYTE_BITS));
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (rd_epoch == epoch_ff && rd_prefix == prefix_ff && rd_byte == byte_ff) begin
               prefix_in = rd_code;
               state_in  = final_ff ? ST_EMIT_LAST : ST_IDLE;
            end else if (rd_epoch == epoch_ff) begin
               // occupied by another pair: probe the next slot
               slot_in  = slot_ff + 1'b1;
               state_in = ST_READ;
            end else begin
               if (next_free_ff < NFW'(CODE_LIMIT)) begin
                  wr_en        = 1'b1;
                  next_free_in = next_free_ff + 1'b1;
               end
               state_in = ST_EMIT_MISS;
            end
         end
         ST_EMIT_MISS: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_code_in  = prefix_ff;
               out_end_in   = 1'b0;
               prefix_in    = CODE_BITS'(byte_ff);
               state_in     = final_ff ? ST_EMIT_LAST : ST_IDLE;
            end
         end
         ST_EMIT_LAST: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_code_in  = prefix_ff;
               out_end_in   = 1'b1;
               next_free_in = NFW'(FIRST_LEARNED);
               // a fresh epoch empties the dictionary; sweep it once epochs run out
               if (epoch_ff == '1) begin
                  epoch_in = EPOCH_BITS'(1);
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end else begin
                  epoch_in = epoch_ff + 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         next_free_ff <= NFW'(FIRST_LEARNED);
         epoch_ff     <= EPOCH_BITS'(1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         next_free_ff <= next_free_in;
         epoch_ff     <= epoch_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff     <= slot_in;
      byte_ff     <= byte_in;
      final_ff    <= final_in;
      prefix_ff   <= prefix_in;
      out_code_ff <= out_code_in;
      out_end_ff  <= out_end_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[slot_ff];
   end

endmodule

[rtl/lzw_compressor_12bit.sv]
// LZW compressor with fixed CODE_BITS-wide codes: one byte per word in, codes out,
// final_byte flushes the prefix and starts a new dictionary. A byte that opens a
// message is only popped. Otherwise its steps are pop, dictionary read and compare,
// then an emit step when the dictionary does not hold the extended string, a read and
// compare more per extra hash probe, and a closing code for a final byte; a word
// waiting in the result register stalls the emit steps. The dictionary lookups depend
// on each other, so the back pops no byte before the last one is through. A clearing
// pass over 2**($clog2(DICT_ENTRIES)+1) slots (8192 by default) follows reset and
// every fifteenth message, and no byte is accepted during it.
module lzw_compressor_12bit import lzwc_pkg::*; #(
   parameter int DICT_ENTRIES = 4096,
   parameter int CODE_BITS    = 12
) (
   input logic       clock,
   input logic       reset,
   lzw_req_if.sink   req_chan,
   lzw_rsp_if.source rsp_chan
);

   item_type        item;
   logic            item_valid;
   logic            item_pop;
   back_status_type status;

   lzwc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .status     (status),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop)
   );

   lzwc_back #(
      .DICT_ENTRIES (DICT_ENTRIES),
      .CODE_BITS    (CODE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .status     (status),
      .rsp_chan   (rsp_chan)
   );

endmodule

[rtl/lzwc_checker.sv]
// Port checker for the LZW compressor and its bind to the top level.
// Depends on lzw_compressor_12bit's ports only.
module lzwc_checker #(
   parameter int CODE_BITS = 12
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [CODE_BITS-1:0] rsp_code
);

   // hold a stalled word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_code))
      else $error("result code changed while stalled");

   // no result straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   // dictionary sweep after reset blocks input
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("input taken during clearing pass");

endmodule

bind lzw_compressor_12bit lzwc_checker #(.CODE_BITS(CODE_BITS)) u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_code  (rsp_chan.out_code)
);

[verif/lzwc_tb_if.sv]
`timescale 1ns / 1ps
// Testbench package for the LZW compressor: code width and code limit.
// The channel interfaces themselves come from rtl/lzwc_if.sv; this file adds none.
package lzwc_tb_pkg;
   localparam int CODE_BITS = 12;
   localparam int CODE_LIMIT = 4096;
endpackage

[verif/testbench.sv]
`timescale 1ns / 1ps
// Testbench for lzw_compressor_12bit: drives bytes with random gaps, predicts
// codes with its own dictionary model and checks every emitted word in order.
// Depends on lzwc_pkg, lzwc_tb_pkg and the channel interfaces.
module testbench;
   import lzwc_pkg::*;
   import lzwc_tb_pkg::*;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 eom;
   } code_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   hold_cycles = 0;
   int   failures = 0;
   int   quiet_cycles = 0;
   code_word_type expected_codes[$];

   // dictionary model
   logic [CODE_BITS-1:0] dict_prefix[CODE_LIMIT];
   logic [7:0]           dict_byte[CODE_LIMIT];
   int                   free_code = FIRST_LEARNED;
   logic [CODE_BITS-1:0] cur_prefix = '0;
   bit                   have_prefix = 0;

   lzw_req_if req_chan ();
   lzw_rsp_if #(.CODE_BITS(CODE_BITS)) rsp_chan ();

   lzw_compressor_12bit dut (.clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source));

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.final_byte = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   task automatic predict_byte(input logic [7:0] b, input bit last);
      int hit;
      hit = -1;
      if (!have_prefix) begin
         cur_prefix = CODE_BITS'(b);
         have_prefix = 1;
      end else begin
         for (int c = FIRST_LEARNED; c < free_code; c++)
            if (dict_prefix[c] == cur_prefix && dict_byte[c] == b) begin
               hit = c;
               break;
            end
         if (hit >= 0) cur_prefix = hit[CODE_BITS-1:0];
         else begin
            expected_codes.push_back('{cur_prefix, 1'b0});
            if (free_code < CODE_LIMIT) begin
               dict_prefix[free_code] = cur_prefix;
               dict_byte[free_code] = b;
               free_code++;
            end
            cur_prefix = CODE_BITS'(b);
         end
      end
      if (last) begin
         expected_codes.push_back('{cur_prefix, 1'b1});
         free_code = FIRST_LEARNED;
         have_prefix = 0;
      end
   endtask

   // offer one byte, hold it until taken, then predict
   task automatic send_byte(input logic [7:0] b, input bit last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= b;
      req_chan.final_byte <= last;
      do @(posedge clock); while (!req_chan.ready);
      predict_byte(b, last);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_chan.ready <= 1'b0;
         end else
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare each accepted word with the oldest prediction
   always @(posedge clock) begin
      code_word_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_codes.size() == 0) begin
            $error("unexpected word: out_code %0d", rsp_chan.out_code);
            failures++;
         end else begin
            want = expected_codes.pop_front();
            if (rsp_chan.out_code !== want.code) begin
               $error("out_code: expected %0d, actual %0d", want.code, rsp_chan.out_code);
               failures++;
            end
            if (rsp_chan.end_of_message !== want.eom) begin
               $error("end_of_message: expected %0d, actual %0d", want.eom,
                  rsp_chan.end_of_message);
               failures++;
            end
         end
      end
   end

   // allow for the dictionary clearing pass before declaring a hang
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 40000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_message(input int len, input int alphabet);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom_range(alphabet - 1)), i == len - 1);
   endtask

   task automatic test_directed();
      send_byte(8'h00, 1);
      send_byte(8'hFF, 1);
      // repeated pattern grows learned strings
      for (int i = 0; i < 12; i++) send_byte(8'(8'h41 + (i % 2)), 0);
      send_byte(8'h41, 1);
      send_byte(8'h55, 0);
      send_byte(8'hAA, 1);
      for (int i = 0; i < 6; i++) send_byte(8'h7F, i == 5);
   endtask

   // long message of fresh pairs keeps growing the dictionary
   task automatic test_long_message();
      for (int i = 0; i < 400; i++)
         send_byte(8'((i * 7 + i / 256) & 8'hFF), 0);
      for (int i = 0; i < 40; i++) send_byte(8'h03, 0);
      send_byte(8'h11, 1);
   endtask

   task automatic test_random(input int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 20);
         send_message(len, ($urandom_range(3) == 0) ? 256 : $urandom_range(2, 6));
         sent += len;
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      send_message(60, 256);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 20;
      recv_idle_pct = 74;
      test_random(350);
      test_backpressure();
      send_idle_pct = 74;
      recv_idle_pct = 20;
      test_random(350);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(350);
      test_long_message();
      req_chan.valid <= 1'b0;
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (failures == 0 && expected_codes.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
